>>> design/hsv_to_rgb_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define HSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define HSV_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, defaults and hue sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // Default number of fraction bits; one turn or full scale is 2^FRAC_BITS.
  localparam int unsigned FRAC_BITS_DEF = 12;

  // Width of the signed input fields.
  localparam int unsigned IN_W = 16;

  // Number of sectors the hue circle is cut into.
  localparam int unsigned HUE_SECTORS = 6;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RY = 3'd0;  // red towards yellow
  localparam sector_t SEC_YG = 3'd1;  // yellow towards green
  localparam sector_t SEC_GC = 3'd2;  // green towards cyan
  localparam sector_t SEC_CB = 3'd3;  // cyan towards blue
  localparam sector_t SEC_BM = 3'd4;  // blue towards magenta
  localparam sector_t SEC_MR = 3'd5;  // magenta towards red

endpackage

`default_nettype wire

>>> design/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts one hue, saturation, brightness item per clock into red, green and
// blue. Inputs are signed fixed point with FRAC_BITS fraction bits; hue wraps
// to its fractional part, saturation and brightness clamp to 0..1. Outputs
// are unsigned with FRAC_BITS fraction bits, full scale being 2^FRAC_BITS.
// The block takes one item every clock unless a stall holds it, through a
// four-stage pipeline (clamp and hue scaling, saturation products,
// brightness products, sector routing into the output register). A stall
// on the output holds the whole pipeline only where it is full; empty stages
// still fill, so in_stall rises only when all are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_unit_assert.svh"

module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [IN_W-1:0] hue_in,
  input  wire logic signed [IN_W-1:0] sat_in,
  input  wire logic signed [IN_W-1:0] bright_in,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [FRAC_BITS:0]          red_out,
  output logic [FRAC_BITS:0]          green_out,
  output logic [FRAC_BITS:0]          blue_out
);

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned HD_W  = FRAC_BITS + 3;
  localparam int unsigned P_W   = 2 * W;
  localparam int unsigned CMP_W = IN_W + 1;
  localparam logic [W-1:0]     ONE     = W'(1) << F;
  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << F;

  // Stage advance enables, from the output back towards the input.
  logic adv1;
  logic adv2;
  logic adv3;
  logic adv4;

  // Stage 1: clamped operands, sector and fraction of the scaled hue.
  logic          v1;
  logic [W-1:0]  s1;
  logic [W-1:0]  b1;
  sector_t       sec1;
  logic [F-1:0]  fr1;

  logic [W-1:0]    s_clamp;
  logic [W-1:0]    b_clamp;
  logic [F-1:0]    hue_frac;
  logic [HD_W-1:0] hue_scaled;

  // Stage 2: complements of the saturation terms.
  logic          v2;
  logic [W-1:0]  b2;
  sector_t       sec2;
  logic [W-1:0]  a1;
  logic [W-1:0]  a2;
  logic [W-1:0]  a3;

  logic [P_W-1:0] p_sfr;
  logic [P_W-1:0] p_sifr;

  // Stage 3: brightness products.
  logic          v3;
  logic [W-1:0]  b3;
  sector_t       sec3;
  logic [W-1:0]  f1;
  logic [W-1:0]  f2;
  logic [W-1:0]  f3;

  logic [P_W-1:0] p_f1;
  logic [P_W-1:0] p_f2;
  logic [P_W-1:0] p_f3;

  logic [W-1:0] red_next;
  logic [W-1:0] green_next;
  logic [W-1:0] blue_next;

  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  // Negative clamps to zero, anything above full scale to full scale.
  always_comb begin
    if (sat_in[IN_W-1]) begin
      s_clamp = '0;
    end else if ({1'b0, sat_in} > ONE_CMP) begin
      s_clamp = ONE;
    end else begin
      s_clamp = W'(sat_in);
    end
    if (bright_in[IN_W-1]) begin
      b_clamp = '0;
    end else if ({1'b0, bright_in} > ONE_CMP) begin
      b_clamp = ONE;
    end else begin
      b_clamp = W'(bright_in);
    end
  end

  // Low bits of the two's complement hue are its true fraction.
  assign hue_frac   = hue_in[F-1:0];
  assign hue_scaled = HD_W'(hue_frac) * HD_W'(HUE_SECTORS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      s1   <= s_clamp;
      b1   <= b_clamp;
      sec1 <= sector_t'(hue_scaled[HD_W-1:F]);
      fr1  <= hue_scaled[F-1:0];
    end
  end

  assign p_sfr  = P_W'(s1) * P_W'(fr1);
  assign p_sifr = P_W'(s1) * P_W'(ONE - W'(fr1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      b2   <= b1;
      sec2 <= sec1;
      a1   <= ONE - s1;
      a2   <= ONE - p_sfr[F +: W];
      a3   <= ONE - p_sifr[F +: W];
    end
  end

  // Each complement is at most full scale, so each product stays within b.
  assign p_f1 = P_W'(b2) * P_W'(a1);
  assign p_f2 = P_W'(b2) * P_W'(a2);
  assign p_f3 = P_W'(b2) * P_W'(a3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      b3   <= b2;
      sec3 <= sec2;
      f1   <= p_f1[F +: W];
      f2   <= p_f2[F +: W];
      f3   <= p_f3[F +: W];
    end
  end

  // Black and grey need no special path: zero brightness zeroes every
  // product, zero saturation makes every product equal the brightness.
  always_comb begin
    unique case (sec3)
      SEC_RY: begin
        red_next = b3; green_next = f3; blue_next = f1;
      end
      SEC_YG: begin
        red_next = f2; green_next = b3; blue_next = f1;
      end
      SEC_GC: begin
        red_next = f1; green_next = b3; blue_next = f3;
      end
      SEC_CB: begin
        red_next = f1; green_next = f2; blue_next = b3;
      end
      SEC_BM: begin
        red_next = f3; green_next = f1; blue_next = b3;
      end
      // Magenta towards red, and the unused codes.
      default: begin
        red_next = b3; green_next = f1; blue_next = f2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv4) begin
      out_valid <= v3;
    end
    if (adv4) begin
      red_out   <= red_next;
      green_out <= green_next;
      blue_out  <= blue_next;
    end
  end

  `HSV_ASSERT_NOW(a_prod_within_bright, clk, rst, v3, (f1 <= b3) && (f2 <= b3) && (f3 <= b3))
  `HSV_ASSERT_NOW(a_out_full_scale, clk, rst, out_valid, (red_out <= ONE) && (green_out <= ONE) && (blue_out <= ONE))
  `HSV_ASSERT_NOW(a_flow_no_stall, clk, rst, !out_valid || !out_stall, !in_stall)
  `HSV_ASSERT_NEXT(a_stall_holds_full, clk, rst, v1 && v2 && v3 && out_valid && out_stall, v1 && v2 && v3)

endmodule

`default_nettype wire

>>> test/hsv_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random hue, saturation, brightness items through the
// converter with random gaps and output stalls, predicts each colour in the
// scoreboard and compares every result field by field, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit_tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned ONE = 1 << FB;
  localparam int unsigned LATENCY = 4;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [FB:0] r;
    logic [FB:0] g;
    logic [FB:0] b;
  } rgb_t;

  class color_scoreboard;
    rgb_t colors_due[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned clamp_level(logic [IN_W-1:0] v);
      if (v[IN_W-1]) return 0;
      if (v > ONE) return ONE;
      return v;
    endfunction

    function rgb_t to_rgb(logic [IN_W-1:0] hue, logic [IN_W-1:0] sat,
                          logic [IN_W-1:0] bright);
      int unsigned h, s, b, hd, fr, f1, f2, f3;
      sector_t     sec;
      rgb_t        res;
      h = hue & (ONE - 1);
      s = clamp_level(sat);
      b = clamp_level(bright);
      res = '0;
      if (b == 0) begin
        res = '0;
      end else if (s == 0) begin
        res.r = b[FB:0];
        res.g = b[FB:0];
        res.b = b[FB:0];
      end else begin
        hd  = h * HUE_SECTORS;
        sec = sector_t'(hd >> FB);
        fr  = hd & (ONE - 1);
        f1  = (b * (ONE - s)) >> FB;
        f2  = (b * (ONE - ((s * fr) >> FB))) >> FB;
        f3  = (b * (ONE - ((s * (ONE - fr)) >> FB))) >> FB;
        case (sec)
          SEC_RY: begin res.r = b[FB:0];  res.g = f3[FB:0]; res.b = f1[FB:0]; end
          SEC_YG: begin res.r = f2[FB:0]; res.g = b[FB:0];  res.b = f1[FB:0]; end
          SEC_GC: begin res.r = f1[FB:0]; res.g = b[FB:0];  res.b = f3[FB:0]; end
          SEC_CB: begin res.r = f1[FB:0]; res.g = f2[FB:0]; res.b = b[FB:0];  end
          SEC_BM: begin res.r = f3[FB:0]; res.g = f1[FB:0]; res.b = b[FB:0];  end
          default: begin res.r = b[FB:0]; res.g = f1[FB:0]; res.b = f2[FB:0]; end
        endcase
      end
      return res;
    endfunction

    function void note_input(logic [IN_W-1:0] hue, logic [IN_W-1:0] sat,
                             logic [IN_W-1:0] bright);
      colors_due.push_back(to_rgb(hue, sat, bright));
    endfunction

    function void check_result(logic [FB:0] r, logic [FB:0] g, logic [FB:0] b);
      rgb_t want;
      if (colors_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d", r, g, b);
        return;
      end
      want = colors_due.pop_front();
      if (want.r !== r || want.g !== g || want.b !== b) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.r, want.g, want.b, r, g, b);
      end
    endfunction

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [IN_W-1:0] hue_in;
  logic signed [IN_W-1:0] sat_in;
  logic signed [IN_W-1:0] bright_in;
  logic                   out_valid;
  logic                   out_stall;
  logic [FB:0]            red_out;
  logic [FB:0]            green_out;
  logic [FB:0]            blue_out;

  color_scoreboard sb;
  int unsigned     items_taken = 0;
  int unsigned     cycles = 0;
  bit              quiet;

  hsv_to_rgb_converter_unit #(.FRAC_BITS(FB)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .hue_in    (hue_in),
    .sat_in    (sat_in),
    .bright_in (bright_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  // Note each accepted item and check each accepted result.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_input(hue_in, sat_in, bright_in);
      items_taken <= items_taken + 1;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_result(red_out, green_out, blue_out);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL hsv_to_rgb_converter_unit");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, a few long ones.
  initial begin
    int hold;
    int r;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall = 1'b0;
        end else if (r < 92) begin
          out_stall = 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Saturation or brightness: mostly in range, with the clamp edges mixed in.
  function automatic logic [IN_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return IN_W'($urandom);
      1: return '0;
      2: return IN_W'(ONE);
      3: begin
        case ($urandom_range(0, 3))
          0: return '1;
          1: return IN_W'(ONE + 1);
          2: return {1'b1, {(IN_W-1){1'b0}}};
          default: return {1'b0, {(IN_W-1){1'b1}}};
        endcase
      end
      default: return IN_W'($urandom_range(1, ONE - 1));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_hue();
    logic [IN_W-1:0] v;
    v = IN_W'($urandom);
    // Land near a sector boundary now and then.
    if ($urandom_range(0, 4) == 0)
      v[FB-1:0] = FB'(($urandom_range(0, 6) * ONE) / HUE_SECTORS
                      + $urandom_range(0, 3) - 1);
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_item(logic [IN_W-1:0] h, logic [IN_W-1:0] s,
                            logic [IN_W-1:0] b);
    int          gap;
    int unsigned target;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    hue_in    = h;
    sat_in    = s;
    bright_in = b;
    target = items_taken + 1;
    @(negedge clk);
    while (items_taken != target) @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    quiet     = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    hue_in    = '0;
    sat_in    = '0;
    bright_in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Each sector, both ends of the hue circle.
    drive_item(16'd0,    16'd4096, 16'd4096);
    drive_item(16'd683,  16'd4096, 16'd4096);
    drive_item(16'd1366, 16'd3000, 16'd4096);
    drive_item(16'd2048, 16'd4096, 16'd3000);
    drive_item(16'd2731, 16'd2048, 16'd4096);
    drive_item(16'd3414, 16'd4096, 16'd4096);
    drive_item(16'd4095, 16'd4096, 16'd4096);
    drive_item(16'd682,  16'd4096, 16'd4096);
    // Negative hues wrap to a true fraction; whole turns drop out.
    drive_item(16'hFFFF, 16'd2048, 16'd4096);
    drive_item(16'h8000, 16'd4096, 16'd4096);
    drive_item(16'h7FFF, 16'd4096, 16'd4096);
    drive_item(16'h1000, 16'd4096, 16'd4096);
    drive_item(16'hEFFF, 16'd4096, 16'd4096);
    drive_item(16'hF000, 16'd4096, 16'd4096);
    // Saturation and brightness out of range clamp.
    drive_item(16'd1000, 16'hFFFF, 16'd4096);
    drive_item(16'd1000, 16'h7FFF, 16'd4096);
    drive_item(16'd1000, 16'h1001, 16'h1001);
    drive_item(16'd1000, 16'h8000, 16'd2000);
    // Black and grey, then mixed hues and levels.
    drive_item(16'd1000, 16'd4096, 16'd0);
    drive_item(16'd1000, 16'd4096, 16'h8000);
    drive_item(16'd1000, 16'd0,    16'd3000);
    drive_item(16'd1000, 16'd0,    16'h7FFF);
    drive_item(16'd2500, 16'd1,    16'd1);
    drive_item(16'hAAAA, 16'h0555, 16'h0AAA);
    drive_item(16'h5555, 16'h0AAA, 16'h0555);

    for (int blk = 0; blk < RANDOM_ITEMS / 50; blk++) begin
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 50; i++)
        drive_item(pick_hue(), pick_level(), pick_level());
      // Hold off the sender until the pipeline has emptied.
      if (blk == 3) drain();
    end
    quiet = 1'b0;

    drain();
    repeat (LATENCY * 4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS hsv_to_rgb_converter_unit");
    end else begin
      $display("FAIL hsv_to_rgb_converter_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
